// ===== rtl/core/pwmru_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmru_pkg
// Types and constants shared by the pulse register update core.
// ----------------------------------------------------------------------------
package pwmru_pkg;

  localparam int DIVIDEND_W = 28;   // 16-bit time scaled by the 4096-step frame
  localparam int DIVISOR_W  = 20;   // period in microseconds, at most 1000000
  localparam int COUNT_W    = 16;
  localparam int FRAME_BITS = 12;
  localparam int FREQ_W     = 11;
  localparam int CHAN_W     = 5;

  localparam logic [DIVISOR_W-1:0] US_PER_S = 20'd1000000;
  localparam logic [CHAN_W-1:0]    ALL_CODE = 5'd16;
  localparam logic [7:0]           CH0_BASE = 8'h06;
  localparam logic [7:0]           ALL_BASE = 8'hFA;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_ON,
    ST_OFF,
    ST_READ,
    ST_CHECK,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BEAT_ON_L,
    BEAT_ON_H,
    BEAT_OFF_L,
    BEAT_OFF_H
  } beat_t;

endpackage

// ===== rtl/core/pwmru_ifs.sv =====
// ----------------------------------------------------------------------------
// pwmru_ifs
// Valid/ready channels of the pulse register update core.
// ----------------------------------------------------------------------------
interface pwmru_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  channel;
  logic [15:0] on_time_us;
  logic [15:0] off_time_us;

  modport source (output valid, output channel, output on_time_us, output off_time_us,
                  input ready);
  modport sink   (input valid, input channel, input on_time_us, input off_time_us,
                  output ready);
endinterface

interface pwmru_wr_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_address;
  logic [7:0] reg_data;
  logic       last_write;

  modport source (output valid, output reg_address, output reg_data, output last_write,
                  input ready);
  modport sink   (input valid, input reg_address, input reg_data, input last_write,
                  output ready);
endinterface

interface pwmru_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] frequency_hz;

  modport source (output valid, output frequency_hz, input ready);
  modport sink   (input valid, input frequency_hz, output ready);
endinterface

// ===== rtl/core/pwmru_div.sv =====
// ----------------------------------------------------------------------------
// pwmru_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmru_div import pwmru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W:0]   rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign shifted = {rem[DIVISOR_W-1:0], quotient[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= CNT_W'(DIVIDEND_W - 1);
    end else if (busy) begin
      // shift the next dividend bit in, subtract when it fits
      rem      <= ge ? diff : shifted;
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

// ===== rtl/core/pwm_pulse_register_update.sv =====
// ----------------------------------------------------------------------------
// pwm_pulse_register_update_core
// Turns on/off times into frame counts and emits four register byte writes,
// skipping requests that repeat the cached counts of a channel.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | accepted when
//  req     | in  | channel, on_time_us, off_time_us          | valid && ready
//  wr      | out | reg_address, reg_data, last_write         | valid && ready
//  cfg     | in  | frequency_hz                              | valid && ready
//
//  At nonzero frequency the shared divider runs one division for the period
//  and one for each of the two counts. At zero frequency the divisions are
//  skipped. A broadcast adds one cache write per channel. req.ready is high
//  only while idle; the next item may enter while the last write waits in the
//  output register.
//  rst clears the cache valid bits and the frequency; cache contents need none.
// ----------------------------------------------------------------------------
module pwm_pulse_register_update_core import pwmru_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic         clk,
  input  logic         rst,
  pwmru_req_if.sink    req,
  pwmru_cfg_if.sink    cfg,
  pwmru_wr_if.source   wr
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_t                state;
  state_t                state_next;
  logic [FREQ_W-1:0]     frequency_hz;
  logic [CHAN_W-1:0]     ch;
  logic [15:0]           on_us;
  logic [15:0]           off_us;
  logic [DIVISOR_W-1:0]  period;
  logic [COUNT_W-1:0]    on_cnt;
  logic [COUNT_W-1:0]    off_cnt;
  logic [NUM_CHANNELS-1:0] entry_valid;
  logic [IDX_W-1:0]      sweep_idx;
  beat_t                 beat;
  logic [2*COUNT_W-1:0]  mem [NUM_CHANNELS];
  logic [2*COUNT_W-1:0]  rd_data;

  logic                  accept;
  logic                  chan_ok;
  logic                  bcast;
  logic [IDX_W-1:0]      idx;
  logic                  hit;
  logic                  out_free;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quo;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [7:0]            base;
  logic [7:0]            byte_data;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign chan_ok   = (req.channel == ALL_CODE) || (req.channel < CHAN_W'(NUM_CHANNELS));
  assign bcast     = (ch == ALL_CODE);
  assign idx       = ch[IDX_W-1:0];
  assign hit       = entry_valid[idx] && (rd_data == {on_cnt, off_cnt});
  assign out_free  = !wr.valid || wr.ready;

  pwmru_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency_hz <= '0;
    end else if (cfg.valid && cfg.ready) begin
      frequency_hz <= cfg.frequency_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = {(DIVIDEND_W - DIVISOR_W)'(0), US_PER_S};
    div_divisor  = {(DIVISOR_W - FREQ_W)'(0), frequency_hz};
    mem_we       = 1'b0;
    mem_waddr    = idx;
    case (state)
      ST_IDLE: begin
        if (accept && chan_ok) begin
          if (frequency_hz != '0) begin
            div_start  = 1'b1;
            state_next = ST_PERIOD;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_PERIOD: begin
        div_dividend = {on_us, FRAME_BITS'(0)};
        div_divisor  = div_quo[DIVISOR_W-1:0];
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_ON;
        end
      end
      ST_ON: begin
        div_dividend = {off_us, FRAME_BITS'(0)};
        div_divisor  = period;
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_OFF;
        end
      end
      ST_OFF: begin
        if (div_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (bcast) begin
          state_next = ST_SWEEP;
        end else if (hit) begin
          state_next = ST_IDLE;
        end else begin
          mem_we     = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_idx;
        if (sweep_idx == IDX_W'(NUM_CHANNELS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && beat == BEAT_OFF_H) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // request fields, counts and sequencing
  always_ff @(posedge clk) begin
    if (accept) begin
      ch      <= req.channel;
      on_us   <= req.on_time_us;
      off_us  <= req.off_time_us;
      on_cnt  <= '0;
      off_cnt <= '0;
    end
    if (state == ST_PERIOD && div_done) begin
      period <= div_quo[DIVISOR_W-1:0];
    end
    if (state == ST_ON && div_done) begin
      on_cnt <= div_quo[COUNT_W-1:0];
    end
    if (state == ST_OFF && div_done) begin
      off_cnt <= div_quo[COUNT_W-1:0];
    end
    if (state == ST_CHECK) begin
      sweep_idx <= '0;
      beat      <= BEAT_ON_L;
    end else if (state == ST_SWEEP) begin
      sweep_idx <= sweep_idx + 1'b1;
    end else if (state == ST_EMIT && out_free) begin
      beat <= beat_t'(beat + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (state == ST_CHECK) begin
      if (bcast) begin
        entry_valid <= '1;
      end else begin
        entry_valid[idx] <= 1'b1;
      end
    end
  end

  // count cache: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {on_cnt, off_cnt};
    end
    rd_data <= mem[idx];
  end

  assign base = bcast ? ALL_BASE : CH0_BASE + {1'b0, ch, 2'b00};

  always_comb begin
    case (beat)
      BEAT_ON_L:  byte_data = on_cnt[7:0];
      BEAT_ON_H:  byte_data = on_cnt[15:8];
      BEAT_OFF_L: byte_data = off_cnt[7:0];
      default:    byte_data = off_cnt[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr.valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      wr.valid <= 1'b1;
    end else if (wr.ready) begin
      wr.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      wr.reg_address <= base + {6'b0, beat};
      wr.reg_data    <= byte_data;
      wr.last_write  <= (beat == BEAT_OFF_H);
    end
  end

endmodule

// ===== rtl/core/pwmru_chk.sv =====
// ----------------------------------------------------------------------------
// pwmru_chk
// Port-level checks of the pulse register update core.
// ----------------------------------------------------------------------------
module pwmru_chk (
  input logic       clk,
  input logic       rst,
  input logic       wr_valid,
  input logic       wr_ready,
  input logic [7:0] wr_reg_address,
  input logic [7:0] wr_reg_data,
  input logic       wr_last_write
);

  // hold a stalled write
  a_wr_hold: assert property (@(posedge clk) disable iff (rst)
    wr_valid && !wr_ready |=> wr_valid && $stable(wr_reg_address) && $stable(wr_reg_data)
                              && $stable(wr_last_write))
    else $error("stalled write item changed");

  // the fourth byte of every run lands on an address ending in 01
  a_last_addr: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> (wr_last_write == (wr_reg_address[1:0] == 2'b01)))
    else $error("last_write does not match the final register of the run");

  // runs start on the on-low register, which ends in 10
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr_ready && wr_last_write |=> !wr_valid || (wr_reg_address[1:0] == 2'b10))
    else $error("run does not start on an on-low register");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !wr_valid)
    else $error("write item shown right after reset");

endmodule

bind pwm_pulse_register_update_core pwmru_chk u_pwmru_chk (
  .clk            (clk),
  .rst            (rst),
  .wr_valid       (wr.valid),
  .wr_ready       (wr.ready),
  .wr_reg_address (wr.reg_address),
  .wr_reg_data    (wr.reg_data),
  .wr_last_write  (wr.last_write)
);

// ===== tb/pwm_pulse_register_update_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_pulse_register_update_core_tb
// Drives on/off time requests and frequency settings into the core. A local
// model converts times to frame counts and tracks the per-channel write cache.
// Every byte write the core emits is compared against the queued prediction.
// ----------------------------------------------------------------------------
module pwm_pulse_register_update_core_tb;
  import pwmru_pkg::*;

  localparam int NUM_CHANNELS = 16;
  localparam int SETTLE_CYCLES = 150;   // slowest item plus a broadcast sweep

  typedef struct packed {
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic       last_write;
  } byte_write_t;

  logic clk;
  logic rst;

  pwmru_req_if req_bus ();
  pwmru_cfg_if cfg_bus ();
  pwmru_wr_if  wr_bus ();

  pwm_pulse_register_update_core #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .cfg(cfg_bus),
    .wr (wr_bus)
  );

  // Model state
  logic [FREQ_W-1:0]  freq_setting;
  bit                 cache_valid [NUM_CHANNELS];
  logic [COUNT_W-1:0] cache_on    [NUM_CHANNELS];
  logic [COUNT_W-1:0] cache_off   [NUM_CHANNELS];
  byte_write_t        pending_writes [$];

  // Last times sent per channel, used to provoke repeated requests
  logic [15:0] last_on  [NUM_CHANNELS];
  logic [15:0] last_off [NUM_CHANNELS];

  int error_count;
  bit feed_steady;
  bit drain_steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [COUNT_W-1:0] frame_count(input logic [15:0] t_us);
    logic [31:0] period_us;
    logic [31:0] scaled;
    if (freq_setting == '0) return '0;
    period_us = 32'(US_PER_S) / 32'(freq_setting);
    scaled = 32'(t_us) << FRAME_BITS;
    return COUNT_W'(scaled / period_us);
  endfunction

  function automatic void predict_request(input logic [4:0] ch, input logic [15:0] on_us,
                                          input logic [15:0] off_us);
    logic [COUNT_W-1:0] on_c;
    logic [COUNT_W-1:0] off_c;
    logic [7:0]         base;
    logic [7:0]         data [4];
    byte_write_t        item;
    on_c = frame_count(on_us);
    off_c = frame_count(off_us);
    if (ch == ALL_CODE) begin
      base = ALL_BASE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cache_valid[i] = 1'b1;
        cache_on[i] = on_c;
        cache_off[i] = off_c;
      end
    end else if (ch < NUM_CHANNELS) begin
      // drop a request that repeats what the channel already holds
      if (cache_valid[ch] && cache_on[ch] == on_c && cache_off[ch] == off_c) return;
      base = CH0_BASE + 8'(4 * ch);
      cache_valid[ch] = 1'b1;
      cache_on[ch] = on_c;
      cache_off[ch] = off_c;
    end else begin
      return;
    end
    data[0] = on_c[7:0];
    data[1] = on_c[15:8];
    data[2] = off_c[7:0];
    data[3] = off_c[15:8];
    for (int i = 0; i < 4; i++) begin
      item.reg_address = base + 8'(i);
      item.reg_data = data[i];
      item.last_write = (i == 3);
      pending_writes.push_back(item);
    end
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      error_count++;
    end
  endfunction

  task automatic send_request(input logic [4:0] ch, input logic [15:0] on_us,
                              input logic [15:0] off_us);
    int gap;
    gap = feed_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.channel <= ch;
    req_bus.on_time_us <= on_us;
    req_bus.off_time_us <= off_us;
    do @(posedge clk); while (!req_bus.ready);
    predict_request(ch, on_us, off_us);
    if (ch == ALL_CODE) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        last_on[i] = on_us;
        last_off[i] = off_us;
      end
    end else if (ch < NUM_CHANNELS) begin
      last_on[ch] = on_us;
      last_off[ch] = off_us;
    end
  endtask

  // Hold the request side until every write has come and the core has settled
  task automatic drain_writes();
    req_bus.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frequency(input logic [FREQ_W-1:0] value);
    drain_writes();
    cfg_bus.valid <= 1'b1;
    cfg_bus.frequency_hz <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    freq_setting = value;
  endtask

  // Frequency left at its reset value: every count is zero
  task automatic test_unset_frequency();
    send_request(5'd0, 16'h1234, 16'hFFFF);
    send_request(5'd0, 16'h0001, 16'h8000);
    send_request(5'd17, 16'hFFFF, 16'hFFFF);
    send_request(5'd31, 16'h5555, 16'hAAAA);
    send_request(ALL_CODE, 16'hAAAA, 16'h5555);
    send_request(5'd15, 16'h0000, 16'h0000);
  endtask

  task automatic test_directed_cases();
    write_frequency(11'd1526);
    send_request(5'd0, 16'h0000, 16'hFFFF);
    send_request(5'd15, 16'hFFFF, 16'h0000);
    send_request(5'd15, 16'hFFFF, 16'h0000);
    send_request(5'd15, 16'hFFFF, 16'h0100);
    send_request(ALL_CODE, 16'd1000, 16'd2000);
    send_request(5'd7, 16'd1000, 16'd2000);
    send_request(5'd7, 16'd2000, 16'd1000);
    // frequency beyond the nominal range still divides
    write_frequency(11'd2047);
    send_request(5'd3, 16'hFFFF, 16'hFFFF);
    send_request(5'd3, 16'h7FFF, 16'h8000);
    // nearby times collapse to equal counts at the lowest frequency
    write_frequency(11'd1);
    send_request(5'd5, 16'd100, 16'd200);
    send_request(5'd5, 16'd101, 16'd201);
    send_request(5'd5, 16'hFFFF, 16'h0000);
    write_frequency(11'd0);
    send_request(5'd9, 16'd5, 16'd5);
    send_request(5'd9, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_random_traffic();
    logic [FREQ_W-1:0] freq;
    logic [4:0]        ch;
    logic [15:0]       on_us;
    logic [15:0]       off_us;
    int                pick;
    int                counted;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: freq = 11'd0;
        1: freq = 11'd1;
        2: freq = 11'd2047;
        3: freq = 11'd1526;
        default: freq = FREQ_W'($urandom_range(1, 2047));
      endcase
      write_frequency(freq);
      feed_steady = (phase == 2);
      drain_steady = (phase == 2 || phase == 5);
      counted = 0;
      while (counted < 32) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) ch = 5'($urandom_range(NUM_CHANNELS + 1, 31));
        else if (pick < 18) ch = ALL_CODE;
        else ch = 5'($urandom_range(0, NUM_CHANNELS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 20 && ch < NUM_CHANNELS) begin
          on_us = last_on[ch];
          off_us = last_off[ch];
        end else if (pick < 30) begin
          on_us = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          off_us = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
          on_us = 16'($urandom);
          off_us = 16'($urandom);
        end
        send_request(ch, on_us, off_us);
        if (ch <= ALL_CODE) counted++;
        // pause mid-phase until all writes are out
        if (phase == 4 && counted == 19) drain_writes();
      end
    end
  endtask

  // Accept and check write items, stalling a random number of cycles before each unless drain_steady is set
  initial begin
    int          stall_left;
    byte_write_t want;
    stall_left = 0;
    wr_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        wr_bus.ready <= 1'b0;
        stall_left = 0;
      end else if (wr_bus.valid && wr_bus.ready) begin
        if (pending_writes.size() == 0) begin
          $display("%0t: unexpected write: expected none, actual addr %h data %h last %b",
                   $time, wr_bus.reg_address, wr_bus.reg_data, wr_bus.last_write);
          error_count++;
        end else begin
          want = pending_writes.pop_front();
          check_field("reg_address", want.reg_address, wr_bus.reg_address);
          check_field("reg_data", want.reg_data, wr_bus.reg_data);
          check_field("last_write", 8'(want.last_write), 8'(wr_bus.last_write));
        end
        stall_left = drain_steady ? 0 : $urandom_range(0, 4);
        wr_bus.ready <= (stall_left == 0);
      end else if (!wr_bus.ready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) wr_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    error_count = 0;
    feed_steady = 1'b0;
    drain_steady = 1'b0;
    freq_setting = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      cache_valid[i] = 1'b0;
      last_on[i] = '0;
      last_off[i] = '0;
    end
    rst <= 1'b1;
    req_bus.valid <= 1'b0;
    req_bus.channel <= '0;
    req_bus.on_time_us <= '0;
    req_bus.off_time_us <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.frequency_hz <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_unset_frequency();
    test_directed_cases();
    test_random_traffic();
    drain_writes();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== pwm_pulse_register_update_core.f =====
rtl/core/pwmru_pkg.sv
rtl/core/pwmru_ifs.sv
rtl/core/pwmru_div.sv
rtl/core/pwm_pulse_register_update.sv
rtl/core/pwmru_chk.sv
tb/pwm_pulse_register_update_core_tb.sv
